// ===== rtl/core/mcsw_pkg.sv =====
// Shared constants and controller/datapath interface types for the stall watchdog.
`timescale 1ns / 1ps

package mcsw_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = $clog2(CHANNELS);
  localparam int USED_W   = $clog2(CHANNELS + 1);

  localparam int ACT_W    = 3;
  localparam int CHAN_W   = 4;
  localparam int TMO_W    = 24;
  localparam int STS_W    = 2;
  localparam int CNT_W    = 4;
  localparam int TIME_W   = 32;
  localparam int CIV_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam logic [ACT_W-1:0] ACT_TICK     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REGISTER = 3'd1;
  localparam logic [ACT_W-1:0] ACT_KICK     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SUSPEND  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESUME   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_ENABLE   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_DISABLE  = 3'd6;

  localparam logic [STS_W-1:0] STS_DONE     = 2'd0;
  localparam logic [STS_W-1:0] STS_REJECTED = 2'd1;
  localparam logic [STS_W-1:0] STS_STALL    = 2'd2;
  localparam logic [STS_W-1:0] STS_IGNORED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT     = 2'd2;

  localparam logic [CIV_W-1:0] RST_CHECK_INTERVAL  = 16'd100;
  localparam logic [TMO_W-1:0] RST_DEFAULT_TIMEOUT = 24'd5000;
  localparam logic [CNT_W-1:0] RST_STALL_LIMIT     = 4'd3;
  localparam logic [CNT_W-1:0] STALL_MAX           = 4'hF;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_step;
    logic close;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_go;
    logic scan_end;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/mcsw_ctrl.sv =====
// Sequencing state machine: accept, execute, channel scan, closing word.
`timescale 1ns / 1ps

module mcsw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          busy_o,
  input  mcsw_pkg::sts_t sts_i,
  output mcsw_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CLOSE
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec      = (state_q == S_EXEC);
    cmd_o.scan_step = (state_q == S_SCAN) && !sts_i.scan_end &&
                      (!sts_i.hit || sts_i.out_free);
    cmd_o.close     = (state_q == S_CLOSE) && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
          busy_d  = 1'b1;
        end
      end
      S_EXEC: begin
        state_d = sts_i.scan_go ? S_SCAN : S_CLOSE;
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== rtl/core/mcsw_datapath.sv =====
// Channel table, time base, configuration registers and output word register.
`timescale 1ns / 1ps

module mcsw_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mcsw_pkg::cmd_t                    cmd_i,
  output mcsw_pkg::sts_t                    sts_o,
  input  logic                              cfg_we_i,
  input  logic [mcsw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mcsw_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic [mcsw_pkg::ACT_W-1:0]        action_i,
  input  logic [mcsw_pkg::CHAN_W-1:0]       channel_i,
  input  logic [mcsw_pkg::TMO_W-1:0]        timeout_ticks_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [mcsw_pkg::STS_W-1:0]        status_o,
  output logic [mcsw_pkg::CHAN_W-1:0]       channel_out_o,
  output logic [mcsw_pkg::CNT_W-1:0]        stall_count_out_o,
  output logic                              recovery_o,
  output logic                              last_o
);

  // configuration
  logic [mcsw_pkg::CIV_W-1:0] interval_q;
  logic [mcsw_pkg::TMO_W-1:0] def_tmo_q;
  logic [mcsw_pkg::CNT_W-1:0] limit_q;

  // latched input word
  logic [mcsw_pkg::ACT_W-1:0]  act_q;
  logic [mcsw_pkg::CHAN_W-1:0] ch_q;
  logic [mcsw_pkg::TMO_W-1:0]  tmo_q;

  // global state
  logic [mcsw_pkg::TIME_W-1:0]  now_q;
  logic [mcsw_pkg::TIME_W-1:0]  last_chk_q;
  logic                         enabled_q;
  logic [mcsw_pkg::USED_W-1:0]  used_q;
  logic [mcsw_pkg::CHANNELS-1:0] active_q;
  logic [mcsw_pkg::USED_W-1:0]  idx_q;

  // channel table, valid only for allocated entries
  logic [mcsw_pkg::TIME_W-1:0] la_q [mcsw_pkg::CHANNELS];
  logic [mcsw_pkg::TMO_W-1:0]  to_q [mcsw_pkg::CHANNELS];
  logic [mcsw_pkg::CNT_W-1:0]  sc_q [mcsw_pkg::CHANNELS];

  // closing word of the current item
  logic [mcsw_pkg::STS_W-1:0]  close_sts_q;
  logic [mcsw_pkg::CHAN_W-1:0] close_chan_q;

  // output word register
  logic                        out_valid_q;
  logic [mcsw_pkg::STS_W-1:0]  out_sts_q;
  logic [mcsw_pkg::CHAN_W-1:0] out_chan_q;
  logic [mcsw_pkg::CNT_W-1:0]  out_cnt_q;
  logic                        out_rec_q;
  logic                        out_last_q;

  logic [mcsw_pkg::CH_W-1:0]   ch_idx;
  logic [mcsw_pkg::CH_W-1:0]   sidx;
  logic                        ch_ok;
  logic [mcsw_pkg::TIME_W-1:0] now_inc;
  logic [mcsw_pkg::TIME_W-1:0] since_chk;
  logic [mcsw_pkg::TIME_W-1:0] elapsed;
  logic                        hit;
  logic [mcsw_pkg::CNT_W-1:0]  sc_new;
  logic                        rec;
  logic                        out_free;

  // table write controls
  logic [mcsw_pkg::CH_W-1:0]   wr_addr;
  logic                        we_la, we_to, we_sc;
  logic [mcsw_pkg::TMO_W-1:0]  to_wval;
  logic [mcsw_pkg::CNT_W-1:0]  sc_wval;
  logic                        act_set, act_clr, used_inc, en_set, en_clr;
  logic [mcsw_pkg::STS_W-1:0]  close_sts_d;
  logic [mcsw_pkg::CHAN_W-1:0] close_chan_d;

  assign ch_idx = ch_q[mcsw_pkg::CH_W-1:0];
  assign sidx   = idx_q[mcsw_pkg::CH_W-1:0];

  always_comb begin
    ch_ok     = {1'b0, ch_q} < used_q;
    now_inc   = now_q + 32'd1;
    since_chk = now_inc - last_chk_q;
    elapsed   = now_q - la_q[sidx];
    hit       = active_q[sidx] && (elapsed > {8'd0, to_q[sidx]});
    sc_new    = (sc_q[sidx] < mcsw_pkg::STALL_MAX) ? sc_q[sidx] + 4'd1
                                                   : mcsw_pkg::STALL_MAX;
    rec       = sc_new >= limit_q;
    out_free  = !out_valid_q || !out_stall_i;
  end

  assign sts_o.scan_go  = (act_q == mcsw_pkg::ACT_TICK) && enabled_q &&
                          (since_chk >= {16'd0, interval_q});
  assign sts_o.scan_end = idx_q >= used_q;
  assign sts_o.hit      = hit;
  assign sts_o.out_free = out_free;

  always_comb begin
    wr_addr      = ch_idx;
    we_la        = 1'b0;
    we_to        = 1'b0;
    we_sc        = 1'b0;
    to_wval      = (tmo_q != '0) ? tmo_q : def_tmo_q;
    sc_wval      = '0;
    act_set      = 1'b0;
    act_clr      = 1'b0;
    used_inc     = 1'b0;
    en_set       = 1'b0;
    en_clr       = 1'b0;
    close_sts_d  = mcsw_pkg::STS_DONE;
    close_chan_d = '0;
    if (cmd_i.exec) begin
      unique case (act_q)
        mcsw_pkg::ACT_TICK: begin
          close_sts_d = mcsw_pkg::STS_DONE;
        end
        mcsw_pkg::ACT_REGISTER: begin
          if (used_q >= mcsw_pkg::USED_W'(mcsw_pkg::CHANNELS)) begin
            close_sts_d = mcsw_pkg::STS_REJECTED;
          end else begin
            wr_addr      = used_q[mcsw_pkg::CH_W-1:0];
            we_la        = 1'b1;
            we_to        = 1'b1;
            we_sc        = 1'b1;
            act_set      = 1'b1;
            used_inc     = 1'b1;
            close_chan_d = mcsw_pkg::CHAN_W'(used_q);
          end
        end
        mcsw_pkg::ACT_KICK: begin
          if (!ch_ok || !active_q[ch_idx]) begin
            close_sts_d = mcsw_pkg::STS_IGNORED;
          end else begin
            we_la = 1'b1;
            we_sc = 1'b1;
          end
        end
        mcsw_pkg::ACT_SUSPEND: begin
          if (!ch_ok) begin
            close_sts_d = mcsw_pkg::STS_IGNORED;
          end else begin
            act_clr = 1'b1;
          end
        end
        mcsw_pkg::ACT_RESUME: begin
          if (!ch_ok) begin
            close_sts_d = mcsw_pkg::STS_IGNORED;
          end else begin
            act_set = 1'b1;
            we_la   = 1'b1;
            we_sc   = 1'b1;
          end
        end
        mcsw_pkg::ACT_ENABLE: begin
          en_set = 1'b1;
        end
        mcsw_pkg::ACT_DISABLE: begin
          en_clr = 1'b1;
        end
        default: begin
          close_sts_d = mcsw_pkg::STS_IGNORED;
        end
      endcase
    end else if (cmd_i.scan_step && hit) begin
      // count the stall; on recovery clear the count and restart the channel's time
      wr_addr = sidx;
      we_sc   = 1'b1;
      sc_wval = rec ? '0 : sc_new;
      we_la   = rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= mcsw_pkg::RST_CHECK_INTERVAL;
      def_tmo_q   <= mcsw_pkg::RST_DEFAULT_TIMEOUT;
      limit_q     <= mcsw_pkg::RST_STALL_LIMIT;
      now_q       <= '0;
      last_chk_q  <= '0;
      enabled_q   <= 1'b0;
      used_q      <= '0;
      active_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mcsw_pkg::CFG_CHECK_INTERVAL:  interval_q <= cfg_data_i[mcsw_pkg::CIV_W-1:0];
          mcsw_pkg::CFG_DEFAULT_TIMEOUT: def_tmo_q  <= cfg_data_i[mcsw_pkg::TMO_W-1:0];
          mcsw_pkg::CFG_STALL_LIMIT:     limit_q    <= cfg_data_i[mcsw_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        idx_q <= '0;
        if (act_q == mcsw_pkg::ACT_TICK) begin
          now_q <= now_inc;
          if (sts_o.scan_go) begin
            last_chk_q <= now_inc;
          end
        end
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
      end
      if (en_set) begin
        enabled_q  <= 1'b1;
        last_chk_q <= now_q;
      end
      if (en_clr) begin
        enabled_q <= 1'b0;
      end
      if (used_inc) begin
        used_q <= used_q + 1'b1;
      end
      if (act_set) begin
        active_q[wr_addr] <= 1'b1;
      end
      if (act_clr) begin
        active_q[wr_addr] <= 1'b0;
      end
      // load the output word, or drop it once taken
      if ((cmd_i.scan_step && hit) || cmd_i.close) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      ch_q  <= channel_i;
      tmo_q <= timeout_ticks_i;
    end
    if (cmd_i.exec) begin
      close_sts_q  <= close_sts_d;
      close_chan_q <= close_chan_d;
    end
    if (we_la) begin
      la_q[wr_addr] <= now_q;
    end
    if (we_to) begin
      to_q[wr_addr] <= to_wval;
    end
    if (we_sc) begin
      sc_q[wr_addr] <= sc_wval;
    end
    if (cmd_i.scan_step && hit) begin
      out_sts_q  <= mcsw_pkg::STS_STALL;
      out_chan_q <= mcsw_pkg::CHAN_W'(sidx);
      out_cnt_q  <= sc_new;
      out_rec_q  <= rec;
      out_last_q <= 1'b0;
    end else if (cmd_i.close) begin
      out_sts_q  <= close_sts_q;
      out_chan_q <= close_chan_q;
      out_cnt_q  <= '0;
      out_rec_q  <= 1'b0;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_sts_q;
  assign channel_out_o     = out_chan_q;
  assign stall_count_out_o = out_cnt_q;
  assign recovery_o        = out_rec_q;
  assign last_o            = out_last_q;

endmodule

// ===== rtl/core/multi_channel_stall_watchdog.sv =====
// Top level of the multi-channel stall watchdog: controller, datapath and checks.
`timescale 1ns / 1ps

// Takes one command word at a time and answers with one closing word (last high),
// preceded on a tick by one stall report per stalled channel in channel order.
// A command other than a scanning tick is latched and executed, then its closing word
// is loaded into the output register; the next word can be accepted after that load.
// A tick that scans walks the channel table one entry per cycle, save while a stall
// report waits on a held output register, through a single elapsed-time subtract and
// compare, visiting each allocated channel and then detecting the end of the table
// before it loads the closing word. A stall on the output side that holds the output
// register delays a pending report or closing word. The input side is ready again as
// soon as the closing word is loaded, while that word still waits to be taken.
// Configuration is written through the plain write port; writes to index 3 are
// ignored.
module multi_channel_stall_watchdog (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mcsw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mcsw_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mcsw_pkg::ACT_W-1:0]     action_i,
  input  logic [mcsw_pkg::CHAN_W-1:0]    channel_i,
  input  logic [mcsw_pkg::TMO_W-1:0]     timeout_ticks_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mcsw_pkg::STS_W-1:0]     status_o,
  output logic [mcsw_pkg::CHAN_W-1:0]    channel_out_o,
  output logic [mcsw_pkg::CNT_W-1:0]     stall_count_out_o,
  output logic                           recovery_o,
  output logic                           last_o
);

  mcsw_pkg::cmd_t cmd;
  mcsw_pkg::sts_t sts;

  mcsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mcsw_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .action_i          (action_i),
    .channel_i         (channel_i),
    .timeout_ticks_i   (timeout_ticks_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .channel_out_o     (channel_out_o),
    .stall_count_out_o (stall_count_out_o),
    .recovery_o        (recovery_o),
    .last_o            (last_o)
  );

`ifndef SYNTHESIS
  // an accepted word keeps the input side busy until its closing word is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input side not busy after accepting a word");

  // going idle means the closing word was just loaded
  a_close_on_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> (out_valid_o && last_o))
    else $error("went idle without a closing word in the output register");

  // recovery is only flagged on a stall report, which is never the closing word
  a_recovery_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && recovery_o) |-> (status_o == mcsw_pkg::STS_STALL && !last_o))
    else $error("recovery flagged outside a stall report");
`endif

endmodule

// ===== dv/stall_watchdog_monitor.sv =====
// Channel monitor for the stall watchdog: predicts each result word and compares it.
`timescale 1ns / 1ps

module stall_watchdog_monitor
  import mcsw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [ACT_W-1:0]     action_i,
  input  logic [CHAN_W-1:0]    channel_i,
  input  logic [TMO_W-1:0]     timeout_ticks_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [STS_W-1:0]     status_i,
  input  logic [CHAN_W-1:0]    channel_out_i,
  input  logic [CNT_W-1:0]     stall_count_out_i,
  input  logic                 recovery_i,
  input  logic                 last_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [CHAN_W-1:0] chan;
    logic [CNT_W-1:0]  count;
    logic              recovery;
    logic              last;
  } report_t;

  report_t expected_reports[$];

  logic [CIV_W-1:0]  scan_interval;
  logic [TMO_W-1:0]  dflt_timeout;
  logic [CNT_W-1:0]  stall_limit;

  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] last_scan;
  logic              running;
  logic [USED_W-1:0] used;
  logic [TIME_W-1:0] seen_at  [CHANNELS];
  logic [TMO_W-1:0]  chan_tmo [CHANNELS];
  logic              watched  [CHANNELS];
  logic [CNT_W-1:0]  stalls   [CHANNELS];

  function automatic void expect_word(input logic [STS_W-1:0] status,
                                      input logic [CHAN_W-1:0] chan,
                                      input logic [CNT_W-1:0] count,
                                      input logic recovery, input logic last);
    report_t w;
    w.status   = status;
    w.chan     = chan;
    w.count    = count;
    w.recovery = recovery;
    w.last     = last;
    expected_reports.push_back(w);
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count_o++;
    end
  endfunction

  task automatic apply_action(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] ch,
                              input logic [TMO_W-1:0] tmo);
    logic              known;
    logic [TIME_W-1:0] elapsed;
    logic              hit_limit;
    known = ({1'b0, ch} < used);
    case (act)
      ACT_TICK: begin
        now = now + 1'b1;
        if (running && (now - last_scan) >= TIME_W'(scan_interval)) begin
          last_scan = now;
          for (int i = 0; i < CHANNELS; i++) begin
            if (i < used && watched[i]) begin
              elapsed = now - seen_at[i];
              if (elapsed > TIME_W'(chan_tmo[i])) begin
                if (stalls[i] != STALL_MAX) stalls[i] = stalls[i] + 1'b1;
                hit_limit = (stalls[i] >= stall_limit);
                expect_word(STS_STALL, CHAN_W'(i), stalls[i], hit_limit, 1'b0);
                // recovery clears the count and restarts the channel's time
                if (hit_limit) begin
                  stalls[i]  = '0;
                  seen_at[i] = now;
                end
              end
            end
          end
        end
        expect_word(STS_DONE, '0, '0, 1'b0, 1'b1);
      end
      ACT_REGISTER: begin
        if (used >= USED_W'(CHANNELS)) begin
          expect_word(STS_REJECTED, '0, '0, 1'b0, 1'b1);
        end else begin
          chan_tmo[used] = (tmo != '0) ? tmo : dflt_timeout;
          seen_at[used]  = now;
          watched[used]  = 1'b1;
          stalls[used]   = '0;
          expect_word(STS_DONE, CHAN_W'(used), '0, 1'b0, 1'b1);
          used = used + 1'b1;
        end
      end
      ACT_KICK: begin
        if (!known || !watched[ch]) begin
          expect_word(STS_IGNORED, '0, '0, 1'b0, 1'b1);
        end else begin
          seen_at[ch] = now;
          stalls[ch]  = '0;
          expect_word(STS_DONE, '0, '0, 1'b0, 1'b1);
        end
      end
      ACT_SUSPEND: begin
        if (!known) begin
          expect_word(STS_IGNORED, '0, '0, 1'b0, 1'b1);
        end else begin
          watched[ch] = 1'b0;
          expect_word(STS_DONE, '0, '0, 1'b0, 1'b1);
        end
      end
      ACT_RESUME: begin
        if (!known) begin
          expect_word(STS_IGNORED, '0, '0, 1'b0, 1'b1);
        end else begin
          watched[ch] = 1'b1;
          seen_at[ch] = now;
          stalls[ch]  = '0;
          expect_word(STS_DONE, '0, '0, 1'b0, 1'b1);
        end
      end
      ACT_ENABLE: begin
        running   = 1'b1;
        last_scan = now;
        expect_word(STS_DONE, '0, '0, 1'b0, 1'b1);
      end
      ACT_DISABLE: begin
        running = 1'b0;
        expect_word(STS_DONE, '0, '0, 1'b0, 1'b1);
      end
      default: expect_word(STS_IGNORED, '0, '0, 1'b0, 1'b1);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      expected_reports.delete();
      mismatch_count_o = 0;
      scan_interval    = RST_CHECK_INTERVAL;
      dflt_timeout     = RST_DEFAULT_TIMEOUT;
      stall_limit      = RST_STALL_LIMIT;
      now              = '0;
      last_scan        = '0;
      running          = 1'b0;
      used             = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        seen_at[i]  = '0;
        chan_tmo[i] = '0;
        watched[i]  = 1'b0;
        stalls[i]   = '0;
      end
    end else begin
      // compare the output word first: it can never stem from an item accepted now
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual status %0d channel %0d",
                   $time, status_i, channel_out_i);
          mismatch_count_o++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", want.status, status_i);
          check_field("channel_out", want.chan, channel_out_i);
          check_field("stall_count_out", want.count, stall_count_out_i);
          check_field("recovery", want.recovery, recovery_i);
          check_field("last", want.last, last_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CHECK_INTERVAL:  scan_interval = cfg_data_i[CIV_W-1:0];
          CFG_DEFAULT_TIMEOUT: dflt_timeout  = cfg_data_i[TMO_W-1:0];
          CFG_STALL_LIMIT:     stall_limit   = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) apply_action(action_i, channel_i, timeout_ticks_i);
    end
    pending_o = expected_reports.size();
  end

endmodule

// ===== dv/multi_channel_stall_watchdog_tb.sv =====
// Testbench top for the stall watchdog: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module multi_channel_stall_watchdog_tb;
  import mcsw_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  localparam int PHASES         = 8;
  localparam int WORDS_PER_PHASE = 60;
  localparam int HOLD_CYCLES    = 300;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [ACT_W-1:0]     action_i        = '0;
  logic [CHAN_W-1:0]    channel_i       = '0;
  logic [TMO_W-1:0]     timeout_ticks_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [STS_W-1:0]     status_o;
  logic [CHAN_W-1:0]    channel_out_o;
  logic [CNT_W-1:0]     stall_count_out_o;
  logic                 recovery_o;
  logic                 last_o;

  int mismatches;
  int pending;
  int idle_mode     = IDLE_NONE;
  int holds_asked   = 0;
  int holds_served  = 0;
  int allocated     = 0;

  // per-phase settings: check interval, default timeout, stall limit
  int unsigned civ_set  [PHASES] = '{1, 2, 1, 65535, 3, 1, 0, 4};
  int unsigned dflt_set [PHASES] = '{3, 16777215, 1, 8, 5, 12, 2, 6};
  int unsigned limit_set[PHASES] = '{1, 15, 4, 2, 3, 15, 2, 5};

  multi_channel_stall_watchdog u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .channel_i         (channel_i),
    .timeout_ticks_i   (timeout_ticks_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .channel_out_o     (channel_out_o),
    .stall_count_out_o (stall_count_out_o),
    .recovery_o        (recovery_o),
    .last_o            (last_o)
  );

  stall_watchdog_monitor u_monitor (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .action_i          (action_i),
    .channel_i         (channel_i),
    .timeout_ticks_i   (timeout_ticks_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_i          (status_o),
    .channel_out_i     (channel_out_o),
    .stall_count_out_i (stall_count_out_o),
    .recovery_i        (recovery_o),
    .last_i            (last_o),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // result side: random stalls per mode, plus long hold-offs on request
  initial begin
    int hold_left;
    int pct;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != holds_asked) begin
        hold_left = HOLD_CYCLES;
        holds_served++;
      end
      pct = (idle_mode == IDLE_RECEIVER) ? 73 : (idle_mode == IDLE_BOTH) ? 36 : 0;
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < pct);
      end
    end
  end

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] ch,
                           input logic [TMO_W-1:0] tmo);
    int pct;
    pct = (idle_mode == IDLE_SENDER) ? 73 : (idle_mode == IDLE_BOTH) ? 36 : 0;
    @(negedge clk_i);
    while ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    channel_i       <= ch;
    timeout_ticks_i <= tmo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (act == ACT_REGISTER && allocated < CHANNELS) allocated++;
  endtask

  // drop valid and hold until every expected word has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_config(input int unsigned civ, input int unsigned dflt,
                              input int unsigned lim);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_CHECK_INTERVAL;
    cfg_data_i  <= CFG_DAT_W'(civ);
    @(negedge clk_i);
    cfg_index_i <= CFG_DEFAULT_TIMEOUT;
    cfg_data_i  <= CFG_DAT_W'(dflt);
    @(negedge clk_i);
    cfg_index_i <= CFG_STALL_LIMIT;
    cfg_data_i  <= CFG_DAT_W'(lim);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_word();
    int unsigned      pick;
    logic [ACT_W-1:0] act;
    logic [CHAN_W-1:0] ch;
    logic [TMO_W-1:0] tmo;
    pick = $urandom_range(99);
    if (pick < 45)      act = ACT_TICK;
    else if (pick < 72) act = ACT_KICK;
    else if (pick < 78) act = ACT_SUSPEND;
    else if (pick < 86) act = ACT_RESUME;
    else if (pick < 92) act = ACT_REGISTER;
    else if (pick < 96) act = ACT_ENABLE;
    else if (pick < 98) act = ACT_DISABLE;
    else                act = ACT_UNUSED;
    // mostly address allocated channels, sometimes any channel
    if (allocated > 0 && $urandom_range(9) < 8) ch = CHAN_W'($urandom_range(allocated - 1));
    else ch = CHAN_W'($urandom);
    tmo = TMO_W'($urandom);
    if (act == ACT_REGISTER) begin
      pick = $urandom_range(99);
      if (pick < 70)      tmo = TMO_W'($urandom_range(40, 1));
      else if (pick < 80) tmo = '0;
    end
    send_word(act, ch, tmo);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: ignored actions, disabled tick, registrations under reset settings
    send_word(ACT_KICK, 4'd0, '0);
    send_word(ACT_SUSPEND, 4'd15, '0);
    send_word(ACT_RESUME, 4'd3, '0);
    send_word(ACT_UNUSED, 4'd15, 24'hFFFFFF);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_REGISTER, '0, '0);
    send_word(ACT_REGISTER, '0, 24'hFFFFFF);
    send_word(ACT_REGISTER, '0, 24'd1);
    send_word(ACT_REGISTER, '0, 24'd2);
    drain_results();

    // zero interval, zero default timeout, zero stall limit
    write_config(0, 0, 0);
    send_word(ACT_REGISTER, '0, '0);
    send_word(ACT_ENABLE, '0, '0);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_KICK, 4'd2, '0);
    send_word(ACT_SUSPEND, 4'd3, '0);
    send_word(ACT_SUSPEND, 4'd3, '0);
    send_word(ACT_KICK, 4'd3, '0);
    send_word(ACT_RESUME, 4'd3, '0);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_DISABLE, '0, '0);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_ENABLE, '0, '0);
    send_word(ACT_TICK, '0, '0);
    send_word(ACT_KICK, 4'd9, '0);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      write_config(civ_set[p], dflt_set[p], limit_set[p]);
      idle_mode = p % 4;
      // long receiver hold-off while the sender keeps offering words
      if (p == 4) holds_asked++;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (p == 6 && k == WORDS_PER_PHASE / 2) drain_results();
        random_word();
      end
      drain_results();
    end

    // make sure the table fills and further registrations are turned away
    for (int k = 0; k < 12; k++) send_word(ACT_REGISTER, CHAN_W'($urandom), TMO_W'($urandom));
    drain_results();
    repeat (40) @(negedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
